// ----- design/uoi_pkg.sv -----
// Shared types, constants and the quarter-wave sine table for the odometry integrator.
// No dependencies; uoi_front, uoi_back and the top refer to it by scoped names.
package uoi_pkg;

    localparam int SINE_DEPTH = 1024;               // entries in the quarter-wave table
    localparam int IDX_W      = $clog2(SINE_DEPTH); // table address bits
    localparam int LUT_W      = IDX_W + 2;          // full-turn lookup index bits
    localparam int QDEPTH     = 2;                  // front-to-back queue entries

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q15_ONE     = 64'd32768;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef logic [15:0] t_rom [SINE_DEPTH];

    typedef struct packed {
        logic               is_load;
        logic signed [15:0] speed;
        logic signed [15:0] rate;
        logic        [15:0] dt;
        logic signed [31:0] load_x;
        logic signed [31:0] load_y;
        logic        [31:0] load_heading;
    } t_item;

    // head of queue, front to back
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_if;

    // back to front
    typedef struct packed {
        logic pop;
        logic filling;
    } t_back_ctrl;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic        [31:0] pose_heading;
        logic signed [15:0] last_speed;
        logic signed [15:0] last_rate;
        logic               saturated;
    } t_result;

    // sin(i*pi/(2*depth)) in Q15: Taylor series to x^11, Q30 angle, truncated terms
    function automatic t_rom build_rom();
        t_rom               rom;
        logic        [63:0] x;
        logic        [63:0] x2;
        logic        [63:0] term;
        logic signed [65:0] sum;
        logic        [63:0] q;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed({2'b00, x});
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - $signed({2'b00, term});
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed({2'b00, term});
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed({2'b00, term});
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed({2'b00, term});
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed({2'b00, term});
            if (sum < 0) begin
                sum = '0;
            end
            q = (sum[63:0] + 64'd16384) >> 15;
            if (q > Q15_ONE) begin
                q = Q15_ONE;
            end
            rom[i] = q[15:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

endpackage

// ----- design/uoi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uoi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/uoi_front.sv -----
// Input side: takes beats, tags step or load, and queues them for the back end.
// Depends on uoi_pkg.
module uoi_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic signed [15:0]  i_lin_speed,
    input  logic signed [15:0]  i_ang_rate,
    input  logic        [15:0]  i_time_step,
    input  logic signed [31:0]  i_load_x,
    input  logic signed [31:0]  i_load_y,
    input  logic        [31:0]  i_load_heading,
    input  uoi_pkg::t_back_ctrl i_ctrl,
    output uoi_pkg::t_queue_if  o_q
);

    uoi_pkg::t_item r_q [uoi_pkg::QDEPTH];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           n_wp;
    logic           n_rp;
    logic [1:0]     n_cnt;
    logic           push;
    logic           pop;
    uoi_pkg::t_item item;

    // no beats while the queue is full or the sine table is being loaded
    assign o_in_stall = (r_cnt == 2'(uoi_pkg::QDEPTH)) || i_ctrl.filling;
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_ctrl.pop && (r_cnt != 2'd0);

    always_comb begin
        item.is_load      = (i_operation == uoi_pkg::OP_LOAD);
        item.speed        = i_lin_speed;
        item.rate         = i_ang_rate;
        item.dt           = i_time_step;
        item.load_x       = i_load_x;
        item.load_y       = i_load_y;
        item.load_heading = i_load_heading;
    end

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.item  = r_q[r_rp];

endmodule

// ----- design/uoi_back.sv -----
// Execution side: sequencer around one shared multiplier and the sine table RAM.
// Holds the pose state and the result register. Depends on uoi_pkg and uoi_ram.
module uoi_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  uoi_pkg::t_queue_if  i_q,
    output uoi_pkg::t_back_ctrl o_ctrl,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output uoi_pkg::t_result    o_res
);

    localparam logic [3:0] ST_FILL = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_TURN = 4'd2;
    localparam logic [3:0] ST_DIST = 4'd3;
    localparam logic [3:0] ST_SIN  = 4'd4;
    localparam logic [3:0] ST_COS  = 4'd5;
    localparam logic [3:0] ST_MULY = 4'd6;
    localparam logic [3:0] ST_MULX = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    localparam int          IW  = uoi_pkg::IDX_W;
    localparam int          LW  = uoi_pkg::LUT_W;
    localparam logic [31:0] RND = 32'd1 << (31 - LW);

    typedef struct packed {
        logic [IW-1:0] addr;
        logic          one;   // position at the end of the quarter: reads as one
        logic          neg;
    } t_lookup;

    typedef struct packed {
        logic signed [31:0] val;
        logic               clip;
    } t_sat;

    function automatic t_lookup lookup(input logic [LW-1:0] idx);
        t_lookup       lk;
        logic [IW-1:0] r;
        r      = idx[IW-1:0];
        lk.neg = idx[LW-1];
        if (idx[LW-2]) begin
            lk.addr = IW'(uoi_pkg::SINE_DEPTH - int'(r));
            lk.one  = (r == '0);
        end else begin
            lk.addr = r;
            lk.one  = 1'b0;
        end
        return lk;
    endfunction

    function automatic logic signed [17:0] trig_val(input logic [15:0] data,
                                                    input t_lookup lk);
        logic [16:0] mag;
        mag = lk.one ? 17'd32768 : {1'b0, data};
        return lk.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // shift right by 23 rounding half up, then saturating add
    function automatic t_sat sat_step(input logic signed [31:0] pos,
                                      input logic signed [49:0] prod);
        t_sat               res;
        logic signed [49:0] rnd;
        logic signed [26:0] dlt;
        logic signed [33:0] sum;
        rnd = prod + 50'sd4194304;
        dlt = 27'(rnd >>> 23);
        sum = 34'(pos) + 34'(dlt);
        res.clip = (sum[33:31] != 3'b000) && (sum[33:31] != 3'b111);
        if (!res.clip) begin
            res.val = sum[31:0];
        end else if (sum[33]) begin
            res.val = 32'sh8000_0000;
        end else begin
            res.val = 32'sh7fff_ffff;
        end
        return res;
    endfunction

    logic [3:0]         r_state,     n_state;
    logic [IW-1:0]      r_fill,      n_fill;
    uoi_pkg::t_item     r_item,      n_item;
    logic        [31:0] r_head,      n_head;
    logic signed [31:0] r_px,        n_px;
    logic signed [31:0] r_py,        n_py;
    logic signed [15:0] r_spd,       n_spd;
    logic signed [15:0] r_rate,      n_rate;
    logic signed [31:0] r_d,         n_d;
    logic signed [17:0] r_sin,       n_sin;
    logic signed [17:0] r_cos,       n_cos;
    t_lookup            r_lk,        n_lk;
    logic signed [49:0] r_prod,      n_prod;
    logic signed [31:0] r_ny,        n_ny;
    logic               r_saty,      n_saty;
    uoi_pkg::t_result   r_out,       n_out;
    logic               r_out_valid, n_out_valid;

    logic signed [31:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [49:0] product;
    logic [LW-1:0]      sin_idx;
    t_lookup            lk_sin;
    t_lookup            lk_cos;
    logic [IW-1:0]      raddr;
    logic [15:0]        rdata;
    logic               ram_we;
    logic               commit;
    logic               pop;
    logic [31:0]        head_rnd;
    t_sat               sat_x;
    t_sat               sat_y;

    uoi_ram #(
        .WIDTH (16),
        .DEPTH (uoi_pkg::SINE_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill),
        .i_wdata (uoi_pkg::SINE_ROM[r_fill]),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign ram_we = (r_state == ST_FILL);

    // shared multiplier
    always_comb begin
        case (r_state)
            ST_TURN: begin
                mul_a = 32'(r_item.rate);
                mul_b = $signed({2'b00, r_item.dt});
            end
            ST_DIST: begin
                mul_a = 32'(r_item.speed);
                mul_b = $signed({2'b00, r_item.dt});
            end
            ST_MULY: begin
                mul_a = r_d;
                mul_b = r_sin;
            end
            default: begin
                mul_a = r_d;
                mul_b = r_cos;
            end
        endcase
        product = 50'(mul_a) * 50'(mul_b);
    end

    assign head_rnd = r_head + RND;
    assign sin_idx  = head_rnd[31 -: LW];
    assign lk_sin   = lookup(sin_idx);
    assign lk_cos   = lookup(sin_idx + LW'(uoi_pkg::SINE_DEPTH));
    assign raddr    = (r_state == ST_COS) ? lk_cos.addr : lk_sin.addr;

    assign sat_y  = sat_step(r_py, r_prod);
    assign sat_x  = sat_step(r_px, r_prod);
    assign commit = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);
    assign pop    = i_q.valid && ((r_state == ST_IDLE) || commit);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_item      = r_item;
        n_head      = r_head;
        n_px        = r_px;
        n_py        = r_py;
        n_spd       = r_spd;
        n_rate      = r_rate;
        n_d         = r_d;
        n_sin       = r_sin;
        n_cos       = r_cos;
        n_lk        = r_lk;
        n_prod      = r_prod;
        n_ny        = r_ny;
        n_saty      = r_saty;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            ST_FILL: begin
                n_fill = r_fill + 1'b1;
                if (r_fill == IW'(uoi_pkg::SINE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
            ST_TURN: begin
                n_prod  = product;
                n_state = ST_DIST;
            end
            ST_DIST: begin
                // turn increment is rate*dt*16 mod 2^32
                n_head  = r_head + {r_prod[27:0], 4'b0000};
                n_d     = product[31:0];
                n_state = ST_SIN;
            end
            ST_SIN: begin
                n_lk    = lk_sin;
                n_state = ST_COS;
            end
            ST_COS: begin
                n_sin   = trig_val(rdata, r_lk);
                n_lk    = lk_cos;
                n_state = ST_MULY;
            end
            ST_MULY: begin
                n_cos   = trig_val(rdata, r_lk);
                n_prod  = product;
                n_state = ST_MULX;
            end
            ST_MULX: begin
                n_ny    = sat_y.val;
                n_saty  = sat_y.clip;
                n_prod  = product;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (commit) begin
                    n_spd  = r_item.speed;
                    n_rate = r_item.rate;
                    if (r_item.is_load) begin
                        n_px   = r_item.load_x;
                        n_py   = r_item.load_y;
                        n_head = r_item.load_heading;
                    end else begin
                        n_px = sat_x.val;
                        n_py = r_ny;
                    end
                    n_out.pose_x       = n_px;
                    n_out.pose_y       = n_py;
                    n_out.pose_heading = n_head;
                    n_out.last_speed   = r_item.speed;
                    n_out.last_rate    = r_item.rate;
                    n_out.saturated    = !r_item.is_load && (sat_x.clip || r_saty);
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (pop) begin
            n_item  = i_q.item;
            n_state = i_q.item.is_load ? ST_FIN : ST_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_spd       <= '0;
            r_rate      <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_px        <= n_px;
            r_py        <= n_py;
            r_spd       <= n_spd;
            r_rate      <= n_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_d    <= n_d;
        r_sin  <= n_sin;
        r_cos  <= n_cos;
        r_lk   <= n_lk;
        r_prod <= n_prod;
        r_ny   <= n_ny;
        r_saty <= n_saty;
        r_out  <= n_out;
    end

    assign o_ctrl.pop     = pop;
    assign o_ctrl.filling = (r_state == ST_FILL);
    assign o_out_valid    = r_out_valid;
    assign o_res          = r_out;

endmodule

// ----- design/unicycle_odometry_integrator.sv -----
// Top level of the dead-reckoning pose integrator.
// Depends on uoi_pkg, uoi_front, uoi_back (and uoi_ram through uoi_back).
//
// Input channel: i_in_valid / o_in_stall with one beat per item. i_operation
// selects a step (integrate speed and turn rate over i_time_step) or a load
// (set pose, held speed and held rate). Output channel: o_out_valid /
// i_out_stall, one result beat per input beat, in order.
// A two-entry queue sits between the input side and the sequencer, and the
// result sits in an output register, so beats keep coming in while a result
// waits for the receiver.
// A step runs the sequencer states turn, distance, sine, cosine, dy, dx and
// finish, a load only finish, each after the queue. A new item starts only
// as the last commits, bound by the one shared multiplier (turn, distance,
// dy, dx) and the single read port of the sine table, which gives sine and
// cosine on successive cycles. Reset clears the pose to zero, then loads all
// 1024 table entries, one entry a cycle; o_in_stall is high in that sweep.
// A stall from the receiver holds the result; once the queue fills,
// o_in_stall rises.
module unicycle_odometry_integrator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic signed [15:0] i_lin_speed,
    input  logic signed [15:0] i_ang_rate,
    input  logic        [15:0] i_time_step,
    input  logic signed [31:0] i_load_x,
    input  logic signed [31:0] i_load_y,
    input  logic        [31:0] i_load_heading,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic        [31:0] o_pose_heading,
    output logic signed [15:0] o_last_speed,
    output logic signed [15:0] o_last_rate,
    output logic               o_saturated
);

    uoi_pkg::t_queue_if  q;
    uoi_pkg::t_back_ctrl ctrl;
    uoi_pkg::t_result    res;

    uoi_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_lin_speed    (i_lin_speed),
        .i_ang_rate     (i_ang_rate),
        .i_time_step    (i_time_step),
        .i_load_x       (i_load_x),
        .i_load_y       (i_load_y),
        .i_load_heading (i_load_heading),
        .i_ctrl         (ctrl),
        .o_q            (q)
    );

    uoi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q),
        .o_ctrl      (ctrl),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (res)
    );

    assign o_pose_x       = res.pose_x;
    assign o_pose_y       = res.pose_y;
    assign o_pose_heading = res.pose_heading;
    assign o_last_speed   = res.last_speed;
    assign o_last_rate    = res.last_rate;
    assign o_saturated    = res.saturated;

endmodule

// ----- tb/unicycle_odometry_integrator_tb.sv -----
// Self-checking testbench for the dead-reckoning pose integrator: a directed table, then
// random step/load beats under several idle patterns, checked against an in-bench predictor.
// Depends on uoi_pkg (item/result types, opcodes, table depth) and the integrator top level.
module unicycle_odometry_integrator_tb;
    import uoi_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRESSURE_HOLD = 200;
    localparam int RANDOM_PER_PHASE = 240;

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
    localparam logic signed [15:0] S16_MIN = 16'sh8000;
    localparam logic        [31:0] QUARTER = 32'h4000_0000;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct {
        t_item   item;
        bit      typed;
        t_result want;
    } directed_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_operation;
    logic signed [15:0] i_lin_speed;
    logic signed [15:0] i_ang_rate;
    logic        [15:0] i_time_step;
    logic signed [31:0] i_load_x;
    logic signed [31:0] i_load_y;
    logic        [31:0] i_load_heading;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_pose_x;
    logic signed [31:0] o_pose_y;
    logic        [31:0] o_pose_heading;
    logic signed [15:0] o_last_speed;
    logic signed [15:0] o_last_rate;
    logic               o_saturated;

    // predictor state
    logic        [15:0] sine_q15 [SINE_DEPTH];
    logic signed [31:0] track_x = '0;
    logic signed [31:0] track_y = '0;
    logic        [31:0] track_hd = '0;

    t_result       pose_expect_q [$];
    directed_row_t directed_rows [$];
    idle_mode_e    idle_mode = IDLE_BOTH;
    int            fail_count = 0;
    int            cycle_count = 0;

    unicycle_odometry_integrator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_lin_speed    (i_lin_speed),
        .i_ang_rate     (i_ang_rate),
        .i_time_step    (i_time_step),
        .i_load_x       (i_load_x),
        .i_load_y       (i_load_y),
        .i_load_heading (i_load_heading),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pose_x       (o_pose_x),
        .o_pose_y       (o_pose_y),
        .o_pose_heading (o_pose_heading),
        .o_last_speed   (o_last_speed),
        .o_last_rate    (o_last_rate),
        .o_saturated    (o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // quarter-wave sine in Q15: Taylor series to x^11 on a Q30 angle, truncated terms
    initial begin
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned rounded;
        longint          series;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            ang    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_DEPTH);
            ang_sq = (ang * ang) >> 30;
            term   = ang;
            series = longint'(ang);
            for (int k = 1; k <= 5; k++) begin
                term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    series = series - longint'(term);
                end else begin
                    series = series + longint'(term);
                end
            end
            if (series < 0) begin
                series = 0;
            end
            rounded = (longint'(series) + 16384) >> 15;
            if (rounded > 32768) begin
                rounded = 32768;
            end
            sine_q15[i] = rounded[15:0];
        end
    end

    function automatic int table_at(int unsigned j);
        return (j >= SINE_DEPTH) ? 32768 : int'(sine_q15[j]);
    endfunction

    function automatic int quarter_wave(int unsigned idx);
        int unsigned quad;
        int unsigned r;
        idx  = idx % (4 * SINE_DEPTH);
        quad = idx / SINE_DEPTH;
        r    = idx % SINE_DEPTH;
        case (quad)
            0:       return table_at(r);
            1:       return table_at(SINE_DEPTH - r);
            2:       return -table_at(r);
            default: return -table_at(SINE_DEPTH - r);
        endcase
    endfunction

    function automatic logic signed [31:0] sat_sum(input logic signed [31:0] base,
                                                   input longint delta,
                                                   inout logic clipped);
        longint s;
        s = longint'(base) + delta;
        if (s > longint'(POS_MAX)) begin
            clipped = 1'b1;
            return POS_MAX;
        end
        if (s < longint'(POS_MIN)) begin
            clipped = 1'b1;
            return POS_MIN;
        end
        return s[31:0];
    endfunction

    // advance the tracked pose by one beat and return the result it must produce
    function automatic t_result advance_pose(t_item it);
        t_result         r;
        longint          turn;
        longint          travel;
        longint unsigned idx;
        int              sin_v;
        int              cos_v;
        logic            clipped;
        clipped = 1'b0;
        if (it.is_load == OP_LOAD) begin
            track_x  = it.load_x;
            track_y  = it.load_y;
            track_hd = it.load_heading;
        end else begin
            turn     = longint'(it.rate) * longint'(it.dt);
            track_hd = track_hd + 32'(turn << 4);
            idx      = (64'(track_hd) * 64'(4 * SINE_DEPTH) + 64'h8000_0000) >> 32;
            sin_v    = quarter_wave(int'(idx));
            cos_v    = quarter_wave(int'(idx) + SINE_DEPTH);
            travel   = longint'(it.speed) * longint'(it.dt);
            // round half up at the 2^-23 point: add half, then floor
            track_x  = sat_sum(track_x, (travel * cos_v + 4194304) >>> 23, clipped);
            track_y  = sat_sum(track_y, (travel * sin_v + 4194304) >>> 23, clipped);
        end
        r.pose_x       = track_x;
        r.pose_y       = track_y;
        r.pose_heading = track_hd;
        r.last_speed   = it.speed;
        r.last_rate    = it.rate;
        r.saturated    = clipped;
        return r;
    endfunction

    task automatic add_row(input logic op, input logic signed [15:0] spd,
                           input logic signed [15:0] rate, input logic [15:0] dt,
                           input logic signed [31:0] lx, input logic signed [31:0] ly,
                           input logic [31:0] lh, input bit typed,
                           input logic signed [31:0] ex, input logic signed [31:0] ey,
                           input logic [31:0] eh, input logic esat);
        directed_row_t row;
        row.item.is_load      = op;
        row.item.speed        = spd;
        row.item.rate         = rate;
        row.item.dt           = dt;
        row.item.load_x       = lx;
        row.item.load_y       = ly;
        row.item.load_heading = lh;
        row.typed             = typed;
        row.want.pose_x       = ex;
        row.want.pose_y       = ey;
        row.want.pose_heading = eh;
        row.want.last_speed   = spd;
        row.want.last_rate    = rate;
        row.want.saturated    = esat;
        directed_rows.push_back(row);
    endtask

    function automatic logic [15:0] pick_half();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // bias toward the rails so steps saturate now and then
    function automatic logic [31:0] pick_pos();
        case ($urandom_range(3))
            0:       return 32'h7FFF_FFFF - 32'($urandom_range(1 << 24));
            1:       return 32'h8000_0000 + 32'($urandom_range(1 << 24));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item make_random_item();
        t_item it;
        it.is_load = ($urandom_range(99) < 8) ? OP_LOAD : OP_STEP;
        it.speed   = pick_half();
        it.rate    = pick_half();
        it.dt      = pick_half();
        it.load_x  = pick_pos();
        it.load_y  = pick_pos();
        if ($urandom_range(3) == 0) begin
            // near a quadrant boundary
            it.load_heading = (32'($urandom_range(3)) << 30) + 32'($urandom_range(1 << 21))
                              - 32'(1 << 20);
        end else begin
            it.load_heading = $urandom;
        end
        return it;
    endfunction

    // offer one beat, hold it until taken, then log what it must produce
    task automatic send_beat(input t_item it, input bit typed, input t_result typed_want);
        int      gap_pct;
        t_result want;
        gap_pct = (idle_mode == IDLE_SEND) ? 88 : (idle_mode == IDLE_BOTH) ? 10 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= it.is_load;
        i_lin_speed    <= it.speed;
        i_ang_rate     <= it.rate;
        i_time_step    <= it.dt;
        i_load_x       <= it.load_x;
        i_load_y       <= it.load_y;
        i_load_heading <= it.load_heading;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        want = advance_pose(it);
        if (typed) begin
            want = typed_want;
        end
        pose_expect_q.push_back(want);
    endtask

    // result side: check accepted beats, drive stall
    initial begin
        t_result got;
        t_result want;
        int      hold_left;
        bit      hold_done;
        int      stall_pct;
        hold_left = 0;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.pose_x       = o_pose_x;
                got.pose_y       = o_pose_y;
                got.pose_heading = o_pose_heading;
                got.last_speed   = o_last_speed;
                got.last_rate    = o_last_rate;
                got.saturated    = o_saturated;
                if (pose_expect_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result beat: x=%h y=%h hd=%h", got.pose_x,
                                 got.pose_y, got.pose_heading);
                    end
                end else begin
                    want = pose_expect_q.pop_front();
                    if (got.pose_x !== want.pose_x || got.pose_y !== want.pose_y ||
                        got.pose_heading !== want.pose_heading ||
                        got.last_speed !== want.last_speed ||
                        got.last_rate !== want.last_rate ||
                        got.saturated !== want.saturated) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("pose mismatch: want x=%h y=%h hd=%h spd=%h rate=%h sat=%b",
                                     want.pose_x, want.pose_y, want.pose_heading,
                                     want.last_speed, want.last_rate, want.saturated);
                            $display("               got  x=%h y=%h hd=%h spd=%h rate=%h sat=%b",
                                     got.pose_x, got.pose_y, got.pose_heading,
                                     got.last_speed, got.last_rate, got.saturated);
                        end
                    end
                end
            end
            // one long hold-off while the sender keeps offering, so the input side backs up
            if (idle_mode == IDLE_NONE && !hold_done) begin
                hold_done = 1'b1;
                hold_left = PRESSURE_HOLD;
            end
            stall_pct = (idle_mode == IDLE_RECV) ? 88 : (idle_mode == IDLE_BOTH) ? 10 : 0;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        idle_mode_e phase_order [4];
        phase_order    = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_operation    <= OP_STEP;
        i_lin_speed    <= '0;
        i_ang_rate     <= '0;
        i_time_step    <= '0;
        i_load_x       <= '0;
        i_load_y       <= '0;
        i_load_heading <= '0;

        // zero time step straight after reset: pose stays at the origin
        add_row(OP_STEP, S16_MAX, S16_MIN, 16'd0, '0, '0, '0, 1, '0, '0, '0, 1'b0);
        add_row(OP_STEP, 16'sd256, 16'sd0, 16'hFFFF, '0, '0, '0, 0, '0, '0, '0, 1'b0);
        add_row(OP_STEP, S16_MAX, S16_MAX, 16'hFFFF, '1, '1, '1, 0, '0, '0, '0, 1'b0);
        add_row(OP_STEP, S16_MIN, S16_MIN, 16'hFFFF, '0, '0, '0, 0, '0, '0, '0, 1'b0);
        add_row(OP_STEP, 16'sd1, 16'sd1, 16'd1, '0, '0, '0, 0, '0, '0, '0, 1'b0);
        add_row(OP_STEP, -16'sd1, -16'sd1, 16'd1, '0, '0, '0, 0, '0, '0, '0, 1'b0);
        add_row(OP_LOAD, S16_MIN, S16_MAX, 16'hFFFF, POS_MAX, POS_MIN, 32'hFFFF_FFFF,
                1, POS_MAX, POS_MIN, 32'hFFFF_FFFF, 1'b0);
        add_row(OP_STEP, 16'sd100, -16'sd100, 16'd0, '0, '0, '0,
                1, POS_MAX, POS_MIN, 32'hFFFF_FFFF, 1'b0);
        // heading wraps past zero from the all-ones heading loaded above
        add_row(OP_STEP, 16'sd0, 16'sd4, 16'd1, '0, '0, '0, 0, '0, '0, '0, 1'b0);
        // drive into each rail along the axes
        add_row(OP_LOAD, 16'sd0, 16'sd0, 16'd0, POS_MAX, '0, '0, 1, POS_MAX, '0, '0, 1'b0);
        add_row(OP_STEP, S16_MAX, 16'sd0, 16'hFFFF, '0, '0, '0, 1, POS_MAX, '0, '0, 1'b1);
        add_row(OP_LOAD, 16'sd0, 16'sd0, 16'd0, POS_MIN, '0, '0, 1, POS_MIN, '0, '0, 1'b0);
        add_row(OP_STEP, S16_MIN, 16'sd0, 16'hFFFF, '0, '0, '0, 1, POS_MIN, '0, '0, 1'b1);
        add_row(OP_LOAD, 16'sd0, 16'sd0, 16'd0, '0, POS_MAX, QUARTER,
                1, '0, POS_MAX, QUARTER, 1'b0);
        add_row(OP_STEP, S16_MAX, 16'sd0, 16'hFFFF, '0, '0, '0, 1, '0, POS_MAX, QUARTER, 1'b1);
        add_row(OP_LOAD, 16'sd0, 16'sd0, 16'd0, '0, POS_MIN, QUARTER,
                1, '0, POS_MIN, QUARTER, 1'b0);
        add_row(OP_STEP, S16_MIN, 16'sd0, 16'hFFFF, '0, '0, '0, 1, '0, POS_MIN, QUARTER, 1'b1);
        add_row(OP_LOAD, 16'sd0, 16'sd0, 16'd0, '0, '0, 32'h8000_0000,
                1, '0, '0, 32'h8000_0000, 1'b0);
        add_row(OP_STEP, S16_MAX, 16'sd0, 16'hFFFF, '0, '0, '0, 0, '0, '0, '0, 1'b0);
        add_row(OP_LOAD, 16'sd7, -16'sd7, 16'd0, '0, '0, 32'hC000_0000,
                1, '0, '0, 32'hC000_0000, 1'b0);
        add_row(OP_STEP, 16'sd1000, -16'sd50, 16'd3000, '0, '0, '0, 0, '0, '0, '0, 1'b0);
        // table index exactly half way between entries rounds up
        add_row(OP_LOAD, 16'sd0, 16'sd0, 16'd0, '0, '0, 32'h0008_0000,
                1, '0, '0, 32'h0008_0000, 1'b0);
        add_row(OP_STEP, 16'sd5000, 16'sd0, 16'd40000, '0, '0, '0, 0, '0, '0, '0, 1'b0);
        add_row(OP_LOAD, 16'sd0, 16'sd0, 16'd0, '0, '0, 32'h0007_FFFF,
                1, '0, '0, 32'h0007_FFFF, 1'b0);
        add_row(OP_STEP, 16'sd5000, 16'sd0, 16'd40000, '0, '0, '0, 0, '0, '0, '0, 1'b0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            send_beat(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].want);
        end

        for (int m = 0; m < 4; m++) begin
            idle_mode = phase_order[m];
            repeat (RANDOM_PER_PHASE) begin
                send_beat(make_random_item(), 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        while (pose_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
